@@ sv/lkp_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkp_pkg: shared types and constants of the led/key panel bus master
// Operation codes, segment kinds, byte selectors, the per-operation segment
// sequence and the item and configuration structs.
// ----------------------------------------------------------------------------
package lkp_pkg;

  // operation codes
  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_SET  = 2'd1;
  localparam logic [1:0] OP_KEYS = 2'd2;
  localparam logic [1:0] OP_OFF  = 2'd3;

  // segment kinds
  localparam logic [1:0] SEG_START = 2'd0;
  localparam logic [1:0] SEG_STOP  = 2'd1;
  localparam logic [1:0] SEG_READ  = 2'd2;
  localparam logic [1:0] SEG_WRITE = 2'd3;

  // byte selectors for write segments
  localparam logic [2:0] WSEL_AUTO  = 3'd0;
  localparam logic [2:0] WSEL_ADDR  = 3'd1;
  localparam logic [2:0] WSEL_WHITE = 3'd2;
  localparam logic [2:0] WSEL_ZERO  = 3'd3;
  localparam logic [2:0] WSEL_RGB   = 3'd4;
  localparam logic [2:0] WSEL_DISP  = 3'd5;
  localparam logic [2:0] WSEL_KEYS  = 3'd6;
  localparam logic [2:0] WSEL_OFF   = 3'd7;

  // configuration register indexes
  localparam logic [2:0] REG_HALF_PERIOD = 3'd0;
  localparam logic [2:0] REG_WRITE_AUTO  = 3'd1;
  localparam logic [2:0] REG_ADDR_ZERO   = 3'd2;
  localparam logic [2:0] REG_DISP_ON     = 3'd3;
  localparam logic [2:0] REG_READ_KEYS   = 3'd4;
  localparam logic [2:0] REG_DISP_OFF    = 3'd5;

  // phase indexes in a segment: last phase, ack phase, and the count of bit phases
  localparam logic [4:0] LAST_PHASE_SHORT = 5'd2;
  localparam logic [4:0] LAST_PHASE_BYTE  = 5'd18;
  localparam logic [4:0] ACK_PHASE        = 5'd17;
  localparam logic [4:0] BIT_PHASES       = 5'd16;

  // classified tick item as it travels through the queue
  typedef struct packed {
    logic [1:0] op;
    logic [4:0] white;
    logic [2:0] rgb;     // rgb mask bits five to three
    logic [2:0] bright;
    logic       dline;
  } lkp_item_t;

  typedef struct packed {
    logic [15:0] half_period;
    logic [7:0]  cmd_write_auto;
    logic [7:0]  cmd_address_zero;
    logic [7:0]  cmd_display_on;
    logic [7:0]  cmd_read_keys;
    logic [7:0]  cmd_display_off;
  } lkp_cfg_t;

  typedef struct packed {
    logic [1:0] kind;
    logic [2:0] wsel;
  } lkp_seg_t;

  // segment at a given step of an operation's sequence
  function automatic lkp_seg_t seq_seg(input logic [1:0] op, input logic [3:0] step);
    lkp_seg_t s;
    s = '{kind: SEG_START, wsel: WSEL_ZERO};
    case (op)
      OP_SET: begin
        case (step)
          4'd0, 4'd3, 4'd10: s = '{kind: SEG_START, wsel: WSEL_ZERO};
          4'd1:              s = '{kind: SEG_WRITE, wsel: WSEL_AUTO};
          4'd2, 4'd9, 4'd12: s = '{kind: SEG_STOP,  wsel: WSEL_ZERO};
          4'd4:              s = '{kind: SEG_WRITE, wsel: WSEL_ADDR};
          4'd5:              s = '{kind: SEG_WRITE, wsel: WSEL_WHITE};
          4'd6, 4'd8:        s = '{kind: SEG_WRITE, wsel: WSEL_ZERO};
          4'd7:              s = '{kind: SEG_WRITE, wsel: WSEL_RGB};
          4'd11:             s = '{kind: SEG_WRITE, wsel: WSEL_DISP};
          default:           s = '{kind: SEG_START, wsel: WSEL_ZERO};
        endcase
      end
      OP_KEYS: begin
        case (step)
          4'd0:    s = '{kind: SEG_START, wsel: WSEL_ZERO};
          4'd1:    s = '{kind: SEG_WRITE, wsel: WSEL_KEYS};
          4'd2:    s = '{kind: SEG_READ,  wsel: WSEL_ZERO};
          default: s = '{kind: SEG_STOP,  wsel: WSEL_ZERO};
        endcase
      end
      OP_OFF: begin
        case (step)
          4'd0:    s = '{kind: SEG_START, wsel: WSEL_ZERO};
          4'd1:    s = '{kind: SEG_WRITE, wsel: WSEL_OFF};
          default: s = '{kind: SEG_STOP,  wsel: WSEL_ZERO};
        endcase
      end
      default: s = '{kind: SEG_START, wsel: WSEL_ZERO};
    endcase
    return s;
  endfunction

  // number of segments of an operation
  function automatic logic [3:0] seq_len(input logic [1:0] op);
    logic [3:0] n;
    case (op)
      OP_SET:  n = 4'd13;
      OP_KEYS: n = 4'd4;
      OP_OFF:  n = 4'd3;
      default: n = 4'd0;
    endcase
    return n;
  endfunction

endpackage
`default_nettype wire

@@ sv/lkp_front.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkp_front: input side of the panel bus master
// Takes tick items, masks the request fields down to the bits in use and
// holds them in a two-entry queue for the bus engine.
// ----------------------------------------------------------------------------
module lkp_front import lkp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_white_mask,
  input  wire logic [7:0] in_rgb_mask,
  input  wire logic [7:0] in_brightness,
  input  wire logic       in_data_line_level,
  output logic            q_valid,
  output lkp_item_t       q_item,
  input  wire logic       q_pop
);

  lkp_item_t  mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       push;
  lkp_item_t  item;

  // classify: keep only the request bits the engine looks at
  always_comb begin
    item.op     = in_operation;
    item.white  = in_white_mask[4:0];
    item.rgb    = in_rgb_mask[5:3];
    item.bright = in_brightness[2:0];
    item.dline  = in_data_line_level;
  end

  assign in_ready = (count_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (count_r != 2'd0);
  assign q_item   = mem_r[rd_ptr_r];

  // queue pointers and fill count
  always_comb begin
    wr_ptr_nxt = push  ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = q_pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

@@ sv/lkp_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkp_engine: bus sequencer of the panel bus master
// Runs one tick per queued item: starts transactions, walks the segment
// sequence and phase timer, samples acknowledges and key bits, and registers
// one result item per tick.
// ----------------------------------------------------------------------------
module lkp_engine import lkp_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire lkp_cfg_t   cfg,
  input  wire logic       q_valid,
  input  wire lkp_item_t  q_item,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic            out_clock_level,
  output logic            out_data_pull_low,
  output logic            out_busy_res,
  output logic            out_done_res,
  output logic            out_ack_ok,
  output logic [7:0]      out_key_bits
);

  // transaction state
  logic        busy_r, busy_nxt;
  logic [3:0]  step_r, step_nxt;
  logic [4:0]  idx_r, idx_nxt;
  logic [15:0] timer_r, timer_nxt;
  logic [7:0]  shift_r, shift_nxt;
  logic        ack_r, ack_nxt;
  logic [1:0]  line_r, line_nxt;
  logic [1:0]  lop_r;
  logic [4:0]  white_r;
  logic [2:0]  rgb_r;
  logic [2:0]  bright_r;

  // result register
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  res_line_r;
  logic        res_busy_r, res_done_r, res_ack_r;
  logic [7:0]  res_keys_r;

  // tick datapath
  logic        start, active;
  logic [1:0]  lop_e;
  logic [4:0]  white_e;
  logic [2:0]  rgb_e, bright_e;
  logic [3:0]  step_e, step_inc;
  logic [4:0]  idx_e;
  logic [15:0] timer_e, timer_dec, period;
  logic [7:0]  shift_e;
  logic        ack_e;
  lkp_seg_t    seg;
  logic [7:0]  wval;
  logic        wbit;
  logic        clk_lvl, pull;
  logic        sample_ack, sample_rd;
  logic        phase_end, seg_end, fin;
  logic        done;
  logic [7:0]  keys;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  assign period = (cfg.half_period == 16'd0) ? 16'd1 : cfg.half_period;

  // pick current or freshly latched transaction context
  always_comb begin
    start    = !busy_r && (q_item.op != OP_NONE);
    active   = busy_r || start;
    lop_e    = start ? q_item.op     : lop_r;
    white_e  = start ? q_item.white  : white_r;
    rgb_e    = start ? q_item.rgb    : rgb_r;
    bright_e = start ? q_item.bright : bright_r;
    step_e   = start ? 4'd0          : step_r;
    idx_e    = start ? 5'd0          : idx_r;
    timer_e  = start ? period        : timer_r;
    shift_e  = start ? 8'd0          : shift_r;
    ack_e    = start ? 1'b1          : ack_r;
  end

  // byte being written in the current segment
  always_comb begin
    seg = seq_seg(lop_e, step_e);
    case (seg.wsel)
      WSEL_AUTO:  wval = cfg.cmd_write_auto;
      WSEL_ADDR:  wval = cfg.cmd_address_zero;
      WSEL_WHITE: wval = {3'b000, white_e};
      WSEL_RGB:   wval = {2'b00, rgb_e, 3'b000};
      WSEL_DISP:  wval = cfg.cmd_display_on | {5'b00000, bright_e};
      WSEL_KEYS:  wval = cfg.cmd_read_keys;
      WSEL_OFF:   wval = cfg.cmd_display_off;
      default:    wval = 8'h00;
    endcase
    wbit = wval[idx_e[3:1]];
  end

  // line levels and sample points of the current phase
  always_comb begin
    clk_lvl    = 1'b0;
    pull       = 1'b0;
    sample_ack = 1'b0;
    sample_rd  = 1'b0;
    case (seg.kind)
      SEG_START: begin
        clk_lvl = (idx_e == 5'd0) || (idx_e == 5'd1);
        pull    = (idx_e != 5'd0);
      end
      SEG_STOP: begin
        clk_lvl = (idx_e != 5'd0);
        pull    = (idx_e == 5'd0) || (idx_e == 5'd1);
      end
      default: begin
        if (idx_e < BIT_PHASES) begin
          clk_lvl = idx_e[0];
          if (seg.kind == SEG_READ) begin
            sample_rd = idx_e[0];
          end else begin
            pull = ~wbit;
          end
        end else if (idx_e == ACK_PHASE) begin
          clk_lvl    = 1'b1;
          sample_ack = (seg.kind == SEG_WRITE);
        end
      end
    endcase
  end

  // phase timer, phase and segment advance, completion
  always_comb begin
    timer_dec = timer_e - {15'd0, timer_e != 16'd0};
    phase_end = (timer_dec == 16'd0);
    seg_end   = (seg.kind == SEG_START || seg.kind == SEG_STOP) ?
                (idx_e == LAST_PHASE_SHORT) : (idx_e == LAST_PHASE_BYTE);
    step_inc  = step_e + 4'd1;

    busy_nxt  = busy_r;
    step_nxt  = step_r;
    idx_nxt   = idx_r;
    timer_nxt = timer_r;
    shift_nxt = shift_r;
    ack_nxt   = ack_r;
    line_nxt  = line_r;
    fin       = 1'b0;
    done      = 1'b0;
    keys      = 8'd0;

    if (active) begin
      busy_nxt  = 1'b1;
      step_nxt  = step_e;
      idx_nxt   = idx_e;
      timer_nxt = timer_dec;
      shift_nxt = shift_e;
      ack_nxt   = ack_e;
      line_nxt  = {clk_lvl, pull};
      if (phase_end) begin
        ack_nxt   = ack_e & ~(sample_ack & q_item.dline);
        shift_nxt = shift_e | ({7'd0, sample_rd & q_item.dline} << idx_e[3:1]);
        if (seg_end) begin
          idx_nxt  = 5'd0;
          step_nxt = step_inc;
          fin      = (step_inc >= seq_len(lop_e));
        end else begin
          idx_nxt  = idx_e + 5'd1;
        end
        if (fin) begin
          busy_nxt = 1'b0;
          step_nxt = 4'd0;
          done     = 1'b1;
          keys     = (lop_e == OP_KEYS) ? shift_nxt : 8'd0;
        end else begin
          timer_nxt = period;
        end
      end
    end
  end

  assign out_valid_nxt = q_pop || (out_valid_r && !out_ready);

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      step_r      <= 4'd0;
      idx_r       <= 5'd0;
      timer_r     <= 16'd0;
      shift_r     <= 8'd0;
      ack_r       <= 1'b1;
      line_r      <= 2'b10;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        busy_r  <= busy_nxt;
        step_r  <= step_nxt;
        idx_r   <= idx_nxt;
        timer_r <= timer_nxt;
        shift_r <= shift_nxt;
        ack_r   <= ack_nxt;
        line_r  <= line_nxt;
      end
    end
  end

  // latched request and result payload
  always_ff @(posedge clk) begin
    if (q_pop) begin
      if (start) begin
        lop_r    <= q_item.op;
        white_r  <= q_item.white;
        rgb_r    <= q_item.rgb;
        bright_r <= q_item.bright;
      end
      res_line_r <= line_nxt;
      res_busy_r <= busy_nxt;
      res_done_r <= done;
      res_ack_r  <= done & ack_nxt;
      res_keys_r <= keys;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_clock_level   = res_line_r[1];
  assign out_data_pull_low = res_line_r[0];
  assign out_busy_res      = res_busy_r;
  assign out_done_res      = res_done_r;
  assign out_ack_ok        = res_ack_r;
  assign out_key_bits      = res_keys_r;

endmodule
`default_nettype wire

@@ sv/led_key_panel_bus_master.sv @@
`timescale 1ns / 1ps
`default_nettype none
// A tick item's result shows once the item has passed the input queue
// storage and then the result register.
// Throughput: one tick item per cycle while out_ready is high, set by the single-tick bus engine.
// Reset (synchronous, rst_n low): queue empty, engine idle, clock line high,
// data released, configuration registers back to their defaults.
// ----------------------------------------------------------------------------
// led_key_panel_bus_master: two-wire led/key panel bus master
// Front queue of tick items, bus engine with a result register, and the
// configuration registers.
// ----------------------------------------------------------------------------
module led_key_panel_bus_master import lkp_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  in_operation,
  input  wire logic [7:0]  in_white_mask,
  input  wire logic [7:0]  in_rgb_mask,
  input  wire logic [7:0]  in_brightness,
  input  wire logic        in_data_line_level,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             out_clock_level,
  output logic             out_data_pull_low,
  output logic             out_busy_res,
  output logic             out_done_res,
  output logic             out_ack_ok,
  output logic [7:0]       out_key_bits,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  lkp_cfg_t  cfg_r;
  logic      q_valid, q_pop;
  lkp_item_t q_item;

  assign cfg_ready = 1'b1;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.half_period      <= 16'd100;
      cfg_r.cmd_write_auto   <= 8'h40;
      cfg_r.cmd_address_zero <= 8'hC0;
      cfg_r.cmd_display_on   <= 8'h88;
      cfg_r.cmd_read_keys    <= 8'h42;
      cfg_r.cmd_display_off  <= 8'h80;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HALF_PERIOD: cfg_r.half_period      <= cfg_data;
        REG_WRITE_AUTO:  cfg_r.cmd_write_auto   <= cfg_data[7:0];
        REG_ADDR_ZERO:   cfg_r.cmd_address_zero <= cfg_data[7:0];
        REG_DISP_ON:     cfg_r.cmd_display_on   <= cfg_data[7:0];
        REG_READ_KEYS:   cfg_r.cmd_read_keys    <= cfg_data[7:0];
        REG_DISP_OFF:    cfg_r.cmd_display_off  <= cfg_data[7:0];
        default:         cfg_r <= cfg_r;
      endcase
    end
  end

  // input side and queue
  lkp_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_operation       (in_operation),
    .in_white_mask      (in_white_mask),
    .in_rgb_mask        (in_rgb_mask),
    .in_brightness      (in_brightness),
    .in_data_line_level (in_data_line_level),
    .q_valid            (q_valid),
    .q_item             (q_item),
    .q_pop              (q_pop)
  );

  // bus engine
  lkp_engine u_engine (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .q_valid           (q_valid),
    .q_item            (q_item),
    .q_pop             (q_pop),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_clock_level   (out_clock_level),
    .out_data_pull_low (out_data_pull_low),
    .out_busy_res      (out_busy_res),
    .out_done_res      (out_done_res),
    .out_ack_ok        (out_ack_ok),
    .out_key_bits      (out_key_bits)
  );

endmodule
`default_nettype wire

@@ sv/lkp_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkp_checker: port-level checks of the panel bus master
// Watches the result channel for consistent status and idle line levels.
// ----------------------------------------------------------------------------
module lkp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic       out_clock_level,
  input wire logic       out_data_pull_low,
  input wire logic       out_busy_res,
  input wire logic       out_done_res,
  input wire logic       out_ack_ok,
  input wire logic [7:0] out_key_bits
);

  // the finishing item never reports busy
  a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_done_res && out_busy_res))
    else $error("done and busy in the same item");

  // ack and key byte only carry data with done
  a_status_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_done_res) |-> (!out_ack_ok && out_key_bits == 8'd0))
    else $error("ack or key bits set without done");

  // an idle bus has clock high and data released
  a_idle_lines: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_busy_res) |-> (out_clock_level && !out_data_pull_low))
    else $error("bus lines not idle outside a transaction");

  // a stalled result item holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_clock_level) && $stable(out_data_pull_low) &&
       $stable(out_busy_res) && $stable(out_done_res) && $stable(out_ack_ok) &&
       $stable(out_key_bits)))
    else $error("stalled result item changed");

endmodule

bind led_key_panel_bus_master lkp_checker u_lkp_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_clock_level   (out_clock_level),
  .out_data_pull_low (out_data_pull_low),
  .out_busy_res      (out_busy_res),
  .out_done_res      (out_done_res),
  .out_ack_ok        (out_ack_ok),
  .out_key_bits      (out_key_bits)
);
`default_nettype wire
